// ===== rtl/lfcs_pkg.sv =====
// ----------------------------------------------------------------------------
// lfcs_pkg
// Shared types and register indexes of the LED flash count sequencer.
// ----------------------------------------------------------------------------
package lfcs_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxBits = 2;
  localparam logic [CfgIdxBits-1:0] CFG_PAUSE_TIME  = 2'd0;
  localparam logic [CfgIdxBits-1:0] CFG_ON_TIME     = 2'd1;
  localparam logic [CfgIdxBits-1:0] CFG_OFF_TIME    = 2'd2;
  localparam logic [CfgIdxBits-1:0] CFG_FLASH_COUNT = 2'd3;

  localparam int unsigned CfgDataBits = 32;
  localparam int unsigned MsBits      = 32;
  localparam int unsigned FlashBits   = 8;

  // One evaluation item
  typedef struct packed {
    logic [MsBits-1:0] now_ms;
    logic              start_request;
    logic              complete_ack;
  } lfcs_in_t;

  // One result item
  typedef struct packed {
    logic                 led_on;
    logic                 burst_complete;
    logic [2:0]           step_code;
    logic [FlashBits-1:0] flashes_done;
  } lfcs_out_t;

endpackage

// ===== rtl/lfcs_stream_if.sv =====
// ----------------------------------------------------------------------------
// lfcs_stream_if
// Valid/ready channel carrying one item of type T.
// ----------------------------------------------------------------------------
interface lfcs_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/lfcs_on_delay.sv =====
// ----------------------------------------------------------------------------
// lfcs_on_delay
// On-delay timer: stamps the time at the rising enable, latches done once
// the wrapped elapsed time reaches the preset. Updates on each item.
// ----------------------------------------------------------------------------
module lfcs_on_delay #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 tick_i,
  input  logic                 enable_i,
  input  logic [TIME_BITS-1:0] now_i,
  input  logic [31:0]          preset_i,
  output logic                 done_o
);

  localparam int unsigned CmpW = (TIME_BITS > 32) ? TIME_BITS : 32;

  logic [TIME_BITS-1:0] stamp_q, stamp_d, elapsed;
  logic                 enable_q;
  logic                 done_q, done_d;

  always_comb begin
    stamp_d = (enable_i && !enable_q) ? now_i : stamp_q;
    elapsed = enable_i ? (now_i - stamp_d) : '0;
    done_d  = enable_i && ((CmpW'(elapsed) >= CmpW'(preset_i)) || done_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stamp_q  <= '0;
      enable_q <= 1'b0;
      done_q   <= 1'b0;
    end else if (tick_i) begin
      stamp_q  <= stamp_d;
      enable_q <= enable_i;
      done_q   <= done_d;
    end
  end

  assign done_o = done_q;

endmodule

// ===== rtl/led_flash_count_sequencer.sv =====
// ----------------------------------------------------------------------------
// led_flash_count_sequencer
// Six-step LED blink sequencer (idle, pause, on, off, count, done) with
// three on-delay timers and a sticky burst complete flag.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake          payload
//  -------   ---  -----------------  ------------------------------------------
//  in_ch     in   valid/ready        now_ms, start_request, complete_ack
//  out_ch    out  valid/ready        led_on, burst_complete, step_code,
//                                    flashes_done
//  cfg       in   cfg_we_i           cfg_idx_i, cfg_data_i (no read-back)
//
//  One item per cycle while out_ch does not stall: the step decode, the
//  flash counter and the three timer compares are combinational between
//  the input port and the result register. An item's result shows the
//  cycle after it is taken. The result register frees itself in the cycle
//  it is taken, so a stall on out_ch holds back in_ch only while a result
//  waits. Reset (rst_ni, async low) puts the sequencer in idle with all
//  timers cleared and flash_count at 1; no clearing pass is needed.
//
module led_flash_count_sequencer #(
  parameter int unsigned TIME_BITS  = 32,
  parameter int unsigned COUNT_BITS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lfcs_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [lfcs_pkg::CfgDataBits-1:0] cfg_data_i,
  lfcs_stream_if.sink                   in_ch,
  lfcs_stream_if.source                 out_ch
);

  import lfcs_pkg::*;

  typedef enum logic [2:0] {
    STEP_IDLE  = 3'd0,
    STEP_PAUSE = 3'd1,
    STEP_ON    = 3'd2,
    STEP_OFF   = 3'd3,
    STEP_COUNT = 3'd4,
    STEP_DONE  = 3'd5
  } step_e;

  // width for comparing the flash counter against flash_count
  localparam int unsigned CntCmpW = (COUNT_BITS > FlashBits) ? COUNT_BITS : FlashBits;
  localparam int unsigned NowW    = (TIME_BITS > MsBits) ? TIME_BITS : MsBits;

  // configuration
  logic [31:0]          pause_time_q, on_time_q, off_time_q;
  logic [FlashBits-1:0] flash_count_q;

  // sequencer state
  step_e                 step_q, step_d;
  logic                  start_q, start_d;
  logic                  complete_q, complete_d;
  logic [COUNT_BITS-1:0] flash_idx_q, flash_idx_d;

  // result register
  lfcs_out_t out_q, out_d;
  logic      out_valid_q;

  logic       accept;
  logic [2:0] tmr_done;
  logic [NowW-1:0]      now_ext;
  logic [TIME_BITS-1:0] now_t;
  logic                 more_flashes;

  assign in_ch.ready = !out_valid_q || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign now_ext = NowW'(in_ch.data.now_ms);
  assign now_t   = now_ext[TIME_BITS-1:0];

  assign more_flashes = CntCmpW'(flash_count_q) > CntCmpW'(flash_idx_q);

  // Next step. Timer done flags are the ones left by the previous item.
  always_comb begin
    start_d    = start_q | in_ch.data.start_request;
    complete_d = complete_q & ~in_ch.data.complete_ack;
    flash_idx_d = flash_idx_q;

    unique case (step_q)
      STEP_IDLE:  step_d = start_d ? STEP_PAUSE : STEP_IDLE;
      STEP_PAUSE: step_d = tmr_done[0] ? STEP_ON : STEP_PAUSE;
      STEP_ON:    step_d = tmr_done[1] ? STEP_OFF : STEP_ON;
      STEP_OFF:   step_d = tmr_done[2] ? STEP_COUNT : STEP_OFF;
      STEP_COUNT: step_d = more_flashes ? STEP_ON : STEP_DONE;
      STEP_DONE:  step_d = STEP_IDLE;
      default:    step_d = STEP_IDLE;
    endcase

    if (step_d == STEP_DONE) complete_d = 1'b1;
    if (step_d == STEP_PAUSE) begin
      start_d     = 1'b0;
      flash_idx_d = '0;
    end
    if (step_d == STEP_COUNT) flash_idx_d = flash_idx_q + 1'b1;

    out_d.led_on         = (step_d == STEP_ON);
    out_d.burst_complete = complete_d;
    out_d.step_code      = step_d;
    out_d.flashes_done   = FlashBits'(CntCmpW'(flash_idx_d));
  end

  // pause, on and off timers
  lfcs_on_delay #(.TIME_BITS(TIME_BITS)) u_tmr_pause (
    .clk_i, .rst_ni, .tick_i(accept), .enable_i(step_d == STEP_PAUSE),
    .now_i(now_t), .preset_i(pause_time_q), .done_o(tmr_done[0])
  );
  lfcs_on_delay #(.TIME_BITS(TIME_BITS)) u_tmr_on (
    .clk_i, .rst_ni, .tick_i(accept), .enable_i(step_d == STEP_ON),
    .now_i(now_t), .preset_i(on_time_q), .done_o(tmr_done[1])
  );
  lfcs_on_delay #(.TIME_BITS(TIME_BITS)) u_tmr_off (
    .clk_i, .rst_ni, .tick_i(accept), .enable_i(step_d == STEP_OFF),
    .now_i(now_t), .preset_i(off_time_q), .done_o(tmr_done[2])
  );

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pause_time_q  <= '0;
      on_time_q     <= '0;
      off_time_q    <= '0;
      flash_count_q <= FlashBits'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PAUSE_TIME:  pause_time_q  <= cfg_data_i;
        CFG_ON_TIME:     on_time_q     <= cfg_data_i;
        CFG_OFF_TIME:    off_time_q    <= cfg_data_i;
        CFG_FLASH_COUNT: flash_count_q <= cfg_data_i[FlashBits-1:0];
        default: ;
      endcase
    end
  end

  // sequencer state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_IDLE;
      start_q     <= 1'b0;
      complete_q  <= 1'b0;
      flash_idx_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        step_q      <= step_d;
        start_q     <= start_d;
        complete_q  <= complete_d;
        flash_idx_q <= flash_idx_d;
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) out_q <= out_d;
  end

  assign out_ch.valid = out_valid_q;
  assign out_ch.data  = out_q;

`ifndef SYNTHESIS
  // count step always resolves on the next item
  a_count_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && step_q == STEP_COUNT) |=> (step_q != STEP_COUNT))
    else $error("count step held over an item");

  // done step always returns to idle
  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && step_q == STEP_DONE) |=> (step_q == STEP_IDLE))
    else $error("done step did not return to idle");

  // LED drive matches the reported step
  a_led_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.led_on == (out_q.step_code == STEP_ON)))
    else $error("led_on disagrees with step_code");

  // a result in the done step carries the complete flag
  a_done_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.step_code == STEP_DONE) |-> out_q.burst_complete)
    else $error("done step without burst_complete");
`endif

endmodule
